[rtl/bphd_pkg.sv]
`timescale 1ns / 1ps
package bphd_pkg;

	localparam int unsigned POSITION_BITS_DEF = 31;

	// header byte count: bytes below HDR_SPLIT fill start/end, then length
	localparam logic [3:0] HDR_SPLIT = 4'd8;
	localparam logic [3:0] HDR_LAST  = 4'd11;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_DATA   = 2'd1;
	localparam logic [1:0] PH_SKIP   = 2'd2;
	localparam logic [1:0] PH_DEAD   = 2'd3;

	localparam logic [1:0] K_NONE   = 2'd0;
	localparam logic [1:0] K_ACCEPT = 2'd1;
	localparam logic [1:0] K_DATA   = 2'd2;
	localparam logic [1:0] K_REJECT = 2'd3;

	typedef struct packed {
		logic [7:0] patch_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] hunk_start;
		logic signed [31:0] hunk_end;
		logic signed [31:0] hunk_length;
		logic [7:0]         data_value;
		logic [30:0]        data_offset;
		logic               finished;
		logic               status;
	} out_item_t;

	// decoder state apart from the byte position, whose width is a parameter
	typedef struct packed {
		logic [1:0]  phase;
		logic [3:0]  hdr_count;
		logic [63:0] hdr_shift0;
		logic [23:0] hdr_shift1;
		logic [30:0] data_remaining;
		logic [30:0] data_index;
		logic        error_flag;
	} dec_state_t;

endpackage

[rtl/bphd_step.sv]
`timescale 1ns / 1ps
module bphd_step #(
	parameter int unsigned POSITION_BITS = bphd_pkg::POSITION_BITS_DEF
) (
	input  bphd_pkg::dec_state_t st,
	input  logic [POSITION_BITS-1:0] pos,
	input  bphd_pkg::in_item_t item,
	output bphd_pkg::dec_state_t st_nx,
	output logic [POSITION_BITS-1:0] pos_nx,
	output bphd_pkg::out_item_t res
);
	import bphd_pkg::*;

	localparam logic [POSITION_BITS-1:0] PosMax = '1;
	localparam logic [31:0] PosLimit = 32'((64'd1 << POSITION_BITS) - 64'd1);

	logic [31:0] hs, he, hl;
	logic [31:0] end_pos;
	logic        err;
	logic        ok;

	assign hs = st.hdr_shift0[63:32];
	assign he = st.hdr_shift0[31:0];
	assign hl = {st.hdr_shift1, item.patch_byte};

	always_comb begin
		st_nx   = st;
		pos_nx  = pos;
		res     = '0;
		err     = st.error_flag;
		ok      = 1'b0;
		end_pos = 32'(pos_nx);

		// count the byte, saturating at the top of the position range
		if (pos == PosMax) begin
			err = 1'b1;
		end else begin
			pos_nx = pos + 1'b1;
		end
		end_pos = 32'(pos_nx) + {1'b0, hl[30:0]};

		unique case (st.phase)
			PH_HEADER: begin
				if (st.hdr_count == HDR_LAST) begin
					res.hunk_start  = hs;
					res.hunk_end    = he;
					res.hunk_length = hl;
					st_nx.hdr_count  = '0;
					st_nx.hdr_shift0 = '0;
					st_nx.hdr_shift1 = '0;
					if (!hl[31] && end_pos > PosLimit) begin
						err = 1'b1;
					end
					if ($signed(hs) > $signed(he) || hl[31]) begin
						res.kind = K_REJECT;
						if (hl[31]) begin
							err = 1'b1;
							st_nx.data_remaining = '0;
							st_nx.phase = PH_DEAD;
						end else begin
							st_nx.data_remaining = hl[30:0];
							st_nx.phase = (hl[30:0] != '0) ? PH_SKIP : PH_DEAD;
						end
					end else begin
						res.kind = K_ACCEPT;
						st_nx.data_remaining = hl[30:0];
						st_nx.data_index = '0;
						st_nx.phase = (hl[30:0] != '0) ? PH_DATA : PH_HEADER;
					end
				end else begin
					st_nx.hdr_count = st.hdr_count + 4'd1;
					if (st.hdr_count < HDR_SPLIT) begin
						st_nx.hdr_shift0 = {st.hdr_shift0[55:0], item.patch_byte};
					end else begin
						st_nx.hdr_shift1 = {st.hdr_shift1[15:0], item.patch_byte};
					end
				end
			end
			PH_DATA: begin
				res.kind        = K_DATA;
				res.data_value  = item.patch_byte;
				res.data_offset = st.data_index;
				st_nx.data_index     = st.data_index + 31'd1;
				st_nx.data_remaining = st.data_remaining - 31'd1;
				if (st.data_remaining == 31'd1) begin
					st_nx.data_index = '0;
					st_nx.phase = PH_HEADER;
				end
			end
			PH_SKIP: begin
				st_nx.data_remaining = st.data_remaining - 31'd1;
				if (st.data_remaining == 31'd1) begin
					st_nx.phase = PH_DEAD;
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase

		st_nx.error_flag = err;
		res.finished = item.last_byte;

		// end of delta: report and start afresh
		if (item.last_byte) begin
			ok = !err && st_nx.hdr_count == '0 &&
				(st_nx.phase == PH_HEADER || st_nx.phase == PH_DEAD);
			res.status = !ok;
			st_nx  = '0;
			pos_nx = '0;
		end
	end

endmodule

[rtl/binary_patch_hunk_decoder_top.sv]
`timescale 1ns / 1ps
// Binary delta hunk decoder. Feed the delta one byte per transaction on the
// input channel, with last_byte set on its final byte; every input byte gives
// exactly one result transaction. A hunk is a 12-byte big-endian header
// (signed start, end, length) followed by its data. The twelfth header byte
// reports the hunk as accepted or rejected, accepted data bytes come out with
// their offset in the hunk, and the result for the last byte carries status:
// 0 when the delta ended cleanly on a hunk boundary, 1 otherwise. Throughput
// is one byte per clock cycle, sustained while the receiver keeps out_ready
// high. The result is registered: the byte is caught in an input register,
// and the whole decode step (header shift, 32-bit compares, counter
// decrement) is a single pass of logic from there into the result register.
// Decoder state returns to reset after every last byte, so back-to-back
// deltas need no gap.
module binary_patch_hunk_decoder_top #(
	parameter int unsigned POSITION_BITS = bphd_pkg::POSITION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bphd_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output bphd_pkg::out_item_t out_item
);
	import bphd_pkg::*;

	logic                     valid_s1;
	in_item_t                 item_s1;
	logic                     adv_s2;

	dec_state_t               state_q, state_nx;
	logic [POSITION_BITS-1:0] pos_q, pos_nx;
	out_item_t                res;
	logic                     out_valid_q;
	out_item_t                out_item_q;

	// the result register frees up when empty or when its transaction completes
	assign adv_s2   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s2;

	// input register: hold while the result side is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	bphd_step #(
		.POSITION_BITS(POSITION_BITS)
	) u_step (
		.st     (state_q),
		.pos    (pos_q),
		.item   (item_s1),
		.st_nx  (state_nx),
		.pos_nx (pos_nx),
		.res    (res)
	);

	// decoder state and result register advance together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s2) begin
				state_q <= state_nx;
				pos_q   <= pos_nx;
			end
			if (adv_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

[rtl/bphd_checker.sv]
`timescale 1ns / 1ps
module bphd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input bphd_pkg::out_item_t out_item
);
	import bphd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result transaction changed while stalled");

	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.finished |-> !out_item.status)
		else $error("status set on a byte that is not the last");

	a_accept_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == K_ACCEPT |->
			out_item.hunk_start <= out_item.hunk_end && !out_item.hunk_length[31])
		else $error("accepted hunk with start above end or negative length");

	a_neg_length_fails: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == K_REJECT && out_item.hunk_length[31] &&
			out_item.finished |-> out_item.status)
		else $error("delta ending on negative-length hunk reported decoded");

	a_data_fields_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind != K_DATA |->
			out_item.data_value == '0 && out_item.data_offset == '0)
		else $error("data fields set on a non-data result");

endmodule

bind binary_patch_hunk_decoder_top bphd_checker u_bphd_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Delta decoder testbench: a directed table first, then random deltas.
// Every accepted byte is run through a local decode model, and the model's
// transaction, or the row's hand-written one where given, is queued; each
// result transaction is compared field by field with the oldest queued entry.
module tb_top;
	import bphd_pkg::*;

	// Narrow the position counter so that hunk lengths near its ceiling come up often.
	localparam int unsigned POS_BITS    = 16;
	localparam logic [31:0] POS_MAX     = 32'((64'd1 << POS_BITS) - 64'd1);
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned RANDOM_BYTES = 1600;

	// One stimulus byte, plus a hand-written result where one is given
	typedef struct packed {
		in_item_t  stim;
		logic      typed;
		out_item_t want;
	} stim_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	bit          idle_on    = 1'b1;
	int unsigned fail_count = 0;

	stim_row_t offered_bytes[$];  // bytes on the input channel, oldest first
	out_item_t due_results[$];    // results still to come, oldest first
	stim_row_t stream_q[$];       // delta under construction

	// Decode model state
	logic [1:0]  dec_phase  = PH_HEADER;
	logic [3:0]  hdr_count  = '0;
	logic [63:0] hdr_word0  = '0;
	logic [31:0] hdr_word1  = '0;
	logic [30:0] bytes_due  = '0;
	logic [30:0] data_idx   = '0;
	logic [31:0] byte_pos   = '0;
	logic        error_seen = 1'b0;

	binary_patch_hunk_decoder_top #(
		.POSITION_BITS(POS_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always #1 clk = ~clk;

	function automatic out_item_t mk_out(logic [1:0] k, logic [31:0] s, logic [31:0] e,
			logic [31:0] l, logic [7:0] v, logic [30:0] off, logic fin, logic st);
		out_item_t r;
		r = '{k, s, e, l, v, off, fin, st};
		return r;
	endfunction

	function automatic stim_row_t raw_row(logic [7:0] b);
		stim_row_t r;
		r = '0;
		r.stim.patch_byte = b;
		return r;
	endfunction

	// Advance the decode model by one byte and return the result it gives
	task automatic decode_byte(input in_item_t it, output out_item_t res);
		logic [31:0] hs, he, hl;
		res = '0;

		// Count the byte, saturating at the ceiling
		if (byte_pos >= POS_MAX)
			error_seen = 1'b1;
		else
			byte_pos++;

		case (dec_phase)
			PH_HEADER: begin
				if (hdr_count < HDR_SPLIT)
					hdr_word0 = {hdr_word0[55:0], it.patch_byte};
				else
					hdr_word1 = {hdr_word1[23:0], it.patch_byte};
				if (hdr_count >= HDR_LAST) begin
					hs = hdr_word0[63:32];
					he = hdr_word0[31:0];
					hl = hdr_word1;
					hdr_count = '0;
					hdr_word0 = '0;
					hdr_word1 = '0;
					res.hunk_start  = hs;
					res.hunk_end    = he;
					res.hunk_length = hl;
					// data that would run past the ceiling is an error up front
					if (!hl[31] && (64'(byte_pos) + 64'(hl) > 64'(POS_MAX)))
						error_seen = 1'b1;
					if ($signed(hs) > $signed(he) || hl[31]) begin
						res.kind = K_REJECT;
						if (hl[31]) begin
							error_seen = 1'b1;
							bytes_due  = '0;
							dec_phase  = PH_DEAD;
						end else begin
							bytes_due = hl[30:0];
							dec_phase = (hl == 0) ? PH_DEAD : PH_SKIP;
						end
					end else begin
						res.kind  = K_ACCEPT;
						bytes_due = hl[30:0];
						data_idx  = '0;
						dec_phase = (hl == 0) ? PH_HEADER : PH_DATA;
					end
				end else begin
					hdr_count++;
				end
			end
			PH_DATA: begin
				res.kind        = K_DATA;
				res.data_value  = it.patch_byte;
				res.data_offset = data_idx;
				data_idx++;
				bytes_due--;
				if (bytes_due == 0) begin
					data_idx  = '0;
					dec_phase = PH_HEADER;
				end
			end
			PH_SKIP: begin
				bytes_due--;
				if (bytes_due == 0)
					dec_phase = PH_DEAD;
			end
			default: begin
				// anything after a rejected hunk's data spoils the delta
				error_seen = 1'b1;
			end
		endcase

		res.finished = it.last_byte;
		if (it.last_byte) begin
			res.status = !(!error_seen && hdr_count == 0 &&
				(dec_phase == PH_HEADER || dec_phase == PH_DEAD));
			// start the next delta from a clean slate
			dec_phase  = PH_HEADER;
			hdr_count  = '0;
			hdr_word0  = '0;
			hdr_word1  = '0;
			bytes_due  = '0;
			data_idx   = '0;
			byte_pos   = '0;
			error_seen = 1'b0;
		end
	endtask

	task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
		fail_count++;
		$display("%0t: %s expected %h, got %h", $time, field, want, got);
	endtask

	// Compare one result transaction with the oldest one due
	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (due_results.size() == 0) begin
			flag("unexpected result, kind", '0, got.kind);
			return;
		end
		want = due_results.pop_front();
		if (got.kind !== want.kind)               flag("kind", want.kind, got.kind);
		if (got.hunk_start !== want.hunk_start)   flag("hunk_start", want.hunk_start,
			got.hunk_start);
		if (got.hunk_end !== want.hunk_end)       flag("hunk_end", want.hunk_end, got.hunk_end);
		if (got.hunk_length !== want.hunk_length) flag("hunk_length", want.hunk_length,
			got.hunk_length);
		if (got.data_value !== want.data_value)   flag("data_value", want.data_value,
			got.data_value);
		if (got.data_offset !== want.data_offset) flag("data_offset", want.data_offset,
			got.data_offset);
		if (got.finished !== want.finished)       flag("finished", want.finished, got.finished);
		if (got.status !== want.status)           flag("status", want.status, got.status);
	endtask

	// Sample both channels at the rising edge. Queue the expectation for an
	// accepted byte first, then check any result transaction.
	always @(posedge clk) begin
		stim_row_t row;
		out_item_t pred;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				row = offered_bytes.pop_front();
				decode_byte(row.stim, pred);
				due_results.push_back(row.typed ? row.want : pred);
			end
			if (out_valid && out_ready)
				check_result(out_item);
		end
	end

	// Offer one byte: optional gap with valid low, then hold until accepted
	task automatic send_row(input stim_row_t row);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		offered_bytes.push_back(row);
		in_item  <= row.stim;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2, 3:    return 32'($urandom_range(0, 16));
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] short_len();
		return ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 8));
	endfunction

	// Append one hunk: header with random offsets in the requested order,
	// then the given number of random data bytes
	task automatic add_hunk(input bit reject, input logic [31:0] len, input int unsigned payload);
		logic [31:0] a, b, lo, hi;
		logic [95:0] hdr;
		int k;
		a = pick_word();
		b = pick_word();
		if (reject && a == b) begin
			a = 32'd1;
			b = 32'd0;
		end else if (!reject && $urandom_range(0, 5) == 0) begin
			b = a;
		end
		if ($signed(a) > $signed(b)) begin
			hi = a;
			lo = b;
		end else begin
			hi = b;
			lo = a;
		end
		hdr = reject ? {hi, lo, len} : {lo, hi, len};
		for (k = 0; k < 12; k++)
			stream_q.push_back(raw_row(hdr[95 - 8 * k -: 8]));
		repeat (payload) stream_q.push_back(raw_row(8'($urandom)));
	endtask

	// Build one random delta, mostly well formed
	task automatic build_delta();
		int unsigned pick, cut;
		logic [31:0] len;
		stim_row_t row;
		stream_q.delete();
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			// clean run of accepted hunks, sometimes closed by a rejected one
			repeat ($urandom_range(1, 4)) begin
				len = short_len();
				add_hunk(1'b0, len, len);
			end
			if ($urandom_range(0, 4) == 0) begin
				len = short_len();
				add_hunk(1'b1, len, len);
			end
		end else if (pick < 65) begin
			// bytes after a rejected hunk's skipped data
			len = 32'($urandom_range(0, 4));
			add_hunk(1'b1, len, len);
			repeat ($urandom_range(1, 3)) stream_q.push_back(raw_row(8'($urandom)));
		end else if (pick < 73) begin
			// negative length
			if ($urandom_range(0, 1)) begin
				len = short_len();
				add_hunk(1'b0, len, len);
			end
			add_hunk(1'($urandom_range(0, 1)), 32'h8000_0000 | $urandom(),
				$urandom_range(0, 3));
		end else if (pick < 83) begin
			// cut short inside a header or inside data
			repeat ($urandom_range(1, 3)) begin
				len = short_len();
				add_hunk(1'b0, len, len);
			end
			cut = $urandom_range(1, 12);
			if (stream_q.size() > cut)
				repeat (cut) void'(stream_q.pop_back());
		end else if (pick < 90) begin
			// lengths that would run past the position ceiling
			len = $urandom_range(0, 1) ? 32'h7FFF_FFFF - 32'($urandom_range(0, 255))
				: POS_MAX - 32'($urandom_range(0, 40));
			add_hunk(1'($urandom_range(0, 1)), len, $urandom_range(0, 5));
		end else begin
			// noise, with the odd early end of delta
			repeat ($urandom_range(1, 24)) begin
				row = raw_row(8'($urandom));
				row.stim.last_byte = ($urandom_range(0, 7) == 0);
				stream_q.push_back(row);
			end
		end
		stream_q[$].stim.last_byte = 1'b1;
	endtask

	// Receiver: insert a random stall before each transaction while idling is on
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = idle_on ? $urandom_range(0, 4) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Hard stop for a hung handshake
	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("binary_patch_hunk_decoder_top verification failed");
		$finish;
	end

	initial begin
		stim_row_t dir_table [27];
		int unsigned random_bytes;
		int i;

		// Hold reset, then release it away from the rising edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: a lone byte, an accepted hunk with extreme offsets and two
		// data bytes, then a rejected hunk of zero length ending the delta
		dir_table = '{
			'{'{8'hA5, 1'b1}, 1'b1, mk_out(K_NONE, 0, 0, 0, 8'h00, 31'd0, 1'b1, 1'b1)},
			'{'{8'h80, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h7F, 1'b0}, 1'b0, '0},
			'{'{8'hFF, 1'b0}, 1'b0, '0},
			'{'{8'hFF, 1'b0}, 1'b0, '0},
			'{'{8'hFF, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h02, 1'b0}, 1'b1, mk_out(K_ACCEPT, 32'h8000_0000, 32'h7FFF_FFFF, 32'd2,
				8'h00, 31'd0, 1'b0, 1'b0)},
			'{'{8'hFF, 1'b0}, 1'b1, mk_out(K_DATA, 0, 0, 0, 8'hFF, 31'd0, 1'b0, 1'b0)},
			'{'{8'h00, 1'b1}, 1'b1, mk_out(K_DATA, 0, 0, 0, 8'h00, 31'd1, 1'b1, 1'b0)},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h01, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b1}, 1'b1, mk_out(K_REJECT, 32'd1, 32'd0, 32'd0, 8'h00, 31'd0,
				1'b1, 1'b0)}
		};
		for (i = 0; i < 27; i++)
			send_row(dir_table[i]);

		// Random deltas; roughly one in four runs with no idling at all
		random_bytes = 0;
		while (random_bytes < RANDOM_BYTES) begin
			build_delta();
			idle_on = ($urandom_range(0, 3) != 0);
			random_bytes += stream_q.size();
			foreach (stream_q[j])
				send_row(stream_q[j]);
		end
		stream_q.delete();

		// Drain, then allow for the pipeline before judging
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0 && due_results.size() == 0)
			$display("binary_patch_hunk_decoder_top verification clean");
		else
			$display("binary_patch_hunk_decoder_top verification failed");
		$finish;
	end

endmodule

[sim.f]
rtl/bphd_pkg.sv
rtl/bphd_step.sv
rtl/binary_patch_hunk_decoder_top.sv
rtl/bphd_checker.sv
tb/tb_top.sv
